>>> rtl/cbi_pkg.sv
// Package for coset barycentric interpolation: BabyBear field constants,
// field types and the modular reduction helpers. No dependencies.
`default_nettype none
package cbi_pkg;
    localparam logic [30:0] FIELD_P = 31'd2013265921;
    localparam logic [3:0]  EXT_W   = 4'd11;
    typedef logic [30:0] fe_t;

    // reduce a 31-bit value (< 2^31 < 2p) to canonical
    function automatic fe_t fcanon(input logic [30:0] v);
        fcanon = (v >= FIELD_P) ? v - FIELD_P : v;
    endfunction

    function automatic fe_t fadd(input fe_t a, input fe_t b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FIELD_P})
            s = s - {1'b0, FIELD_P};
        fadd = s[30:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/cbi_mulmod.sv
// Pipelined modular multiplier for the BabyBear field: product, then
// reduction by a reciprocal estimate and up to two corrections. Uses cbi_pkg.
`default_nettype none
module cbi_mulmod
    import cbi_pkg::*;
(
    input  wire logic clk,
    input  wire fe_t  a,
    input  wire fe_t  b,
    output fe_t       r
);
    // floor(2^63 / p); quotient estimate from product bits 61:30, never high,
    // at most two low
    localparam logic [32:0] MU = 33'd4581298446;
    logic [61:0] prod_reg;
    logic [61:0] prod2_reg;
    logic [32:0] q_reg;
    logic [64:0] qfull;
    logic [63:0] rem;
    logic [63:0] rem_next;

    assign qfull = 65'(prod_reg[61:30]) * 65'(MU);
    assign rem = {2'b0, prod2_reg} - ({31'b0, q_reg} * {33'b0, FIELD_P});

    always_comb
    begin
        rem_next = rem;
        if (rem_next >= {33'b0, FIELD_P})
            rem_next = rem_next - {33'b0, FIELD_P};
        if (rem_next >= {33'b0, FIELD_P})
            rem_next = rem_next - {33'b0, FIELD_P};
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= {31'b0, a} * {31'b0, b};
        prod2_reg <= prod_reg;
        q_reg     <= {1'b0, qfull[64:33]};
        r         <= rem_next[30:0];
    end
endmodule
`default_nettype wire

>>> rtl/coset_barycentric_interpolation.sv
// Coset barycentric interpolation, BabyBear quartic extension (x^4 - 11).
// Top level: accumulator memory, sequencer, uses cbi_pkg and cbi_mulmod.
//
// One matrix element is taken per transfer. The sequencer handles one item
// at a time: 8 products (x*d, then v*(x*d), one per limb) through one
// 3-stage multiplier, one product in flight at a time, a memory read and
// write-back of the column accumulator (zeroed on the last row), and on the
// last row 16 scaler products plus 3 folds by 11. The input is stalled until
// the item is through; results come only from last-row items.
// After reset a clearing pass over all MAX_COLUMNS addresses zeroes the
// accumulator memory while no item is taken. Columns >= MAX_COLUMNS are
// dropped. The result moves to an output register and waits there until
// its transfer, so the next item can start; a further result waits in the
// sequencer and holds off the input.
`default_nettype none
module coset_barycentric_interpolation
    import cbi_pkg::*;
#(
    parameter int MAX_COLUMNS = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] column,
    input  wire logic [30:0] eval_value,
    input  wire logic [30:0] coset_point,
    input  wire logic [30:0] diff_inv_c0,
    input  wire logic [30:0] diff_inv_c1,
    input  wire logic [30:0] diff_inv_c2,
    input  wire logic [30:0] diff_inv_c3,
    input  wire logic       last_row,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_column,
    output logic [30:0]     value_c0,
    output logic [30:0]     value_c1,
    output logic [30:0]     value_c2,
    output logic [30:0]     value_c3,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [30:0] cfg_data
);
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MUL = 4'd2,
                           S_RD = 4'd3, S_ADD = 4'd4, S_SC = 4'd5,
                           S_OUT = 4'd6;

    logic [3:0]   state_reg;
    logic [AW:0]  clr_reg;
    logic [7:0]   col_reg;
    logic         last_reg;
    fe_t          ev_reg, xp_reg;
    fe_t          d_reg [4];
    fe_t          acc_reg [4];
    fe_t          res_reg [4];
    fe_t          sc_reg [4];
    logic [5:0]   step_reg;   // issue counter
    logic [1:0]   wb_reg;     // cycles into the current product
    logic [7:0]   out_col_reg;
    fe_t          out_val_reg [4];

    logic [123:0] mem [MAX_COLUMNS];
    logic [123:0] rd_reg;
    logic         we;
    logic [AW-1:0] wa;
    logic [AW-1:0] col_addr;
    logic [123:0] wd;

    fe_t ma, mb, mr;
    cbi_mulmod u_mul (.clk(clk), .a(ma), .b(mb), .r(mr));

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign col_addr  = AW'(col_reg);
    assign out_column = out_col_reg;
    assign value_c0 = out_val_reg[0];
    assign value_c1 = out_val_reg[1];
    assign value_c2 = out_val_reg[2];
    assign value_c3 = out_val_reg[3];

    // step layout for S_MUL: 0..3 x*d, 4..7 v*(xd)
    // for S_SC: step i*4+j -> acc[i]*sc[j]; steps 16..18 -> res[j+1]*11
    logic [1:0] si, sj;
    assign si = step_reg[3:2];
    assign sj = step_reg[1:0];

    always_comb
    begin
        ma = xp_reg;
        mb = d_reg[sj];
        if (state_reg == S_MUL && step_reg[2])
        begin
            ma = ev_reg;
            mb = d_reg[sj];
        end
        if (state_reg == S_SC)
        begin
            ma = acc_reg[si];
            mb = sc_reg[sj];
        end
        if (state_reg == S_SC && step_reg[4])
        begin
            ma = res_reg[step_reg[1:0] + 2'd1];
            mb = {27'b0, EXT_W};
        end
    end

    always_comb
    begin
        we = 1'b0;
        wa = clr_reg[AW-1:0];
        wd = '0;
        if (state_reg == S_CLR)
            we = 1'b1;
        if (state_reg == S_ADD)
        begin
            we = 1'b1;
            wa = col_addr;
            if (!last_reg)
                wd = {fadd(rd_reg[123:93], d_reg[3]), fadd(rd_reg[92:62], d_reg[2]),
                      fadd(rd_reg[61:31], d_reg[1]), fadd(rd_reg[30:0], d_reg[0])};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[col_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            step_reg  <= '0;
            wb_reg    <= '0;
            sc_reg[0] <= 31'd1;
            sc_reg[1] <= '0;
            sc_reg[2] <= '0;
            sc_reg[3] <= '0;
        end
        else
        begin
            if (cfg_valid)
                sc_reg[cfg_index] <= fcanon(cfg_data);
            // post the finished result once the output register is free
            if (state_reg == S_OUT && (!out_valid || !out_stall))
            begin
                out_valid      <= 1'b1;
                out_col_reg    <= col_reg;
                out_val_reg[0] <= res_reg[0];
                out_val_reg[1] <= res_reg[1];
                out_val_reg[2] <= res_reg[2];
                out_val_reg[3] <= res_reg[3];
            end
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(MAX_COLUMNS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall &&
                        (int'({24'b0, column}) < MAX_COLUMNS))
                    begin
                        col_reg  <= column;
                        last_reg <= last_row;
                        ev_reg   <= fcanon(eval_value);
                        xp_reg   <= fcanon(coset_point);
                        d_reg[0] <= fcanon(diff_inv_c0);
                        d_reg[1] <= fcanon(diff_inv_c1);
                        d_reg[2] <= fcanon(diff_inv_c2);
                        d_reg[3] <= fcanon(diff_inv_c3);
                        step_reg <= '0;
                        wb_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // one limb in flight at a time per phase
                    if (wb_reg == 2'd3)
                    begin
                        d_reg[step_reg[1:0]] <= mr;
                        wb_reg <= '0;
                        if (step_reg[2:0] == 3'd7)
                            state_reg <= S_RD;
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                        wb_reg <= wb_reg + 1'b1;
                end
                S_RD:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    acc_reg[0] <= fadd(rd_reg[30:0], d_reg[0]);
                    acc_reg[1] <= fadd(rd_reg[61:31], d_reg[1]);
                    acc_reg[2] <= fadd(rd_reg[92:62], d_reg[2]);
                    acc_reg[3] <= fadd(rd_reg[123:93], d_reg[3]);
                    res_reg[0] <= '0;
                    res_reg[1] <= '0;
                    res_reg[2] <= '0;
                    res_reg[3] <= '0;
                    step_reg <= '0;
                    wb_reg   <= '0;
                    state_reg <= last_reg ? S_SC : S_IDLE;
                end
                S_SC:
                begin
                    // 16 products: lo sums in res, hi sums in d_reg (the first
                    // hi term of each sum has j = 3); then hi moves to res[1..3],
                    // lo to acc, and 3 folds by 11
                    if (wb_reg == 2'd3)
                    begin
                        wb_reg <= '0;
                        step_reg <= step_reg + 1'b1;
                        if (!step_reg[4])
                        begin
                            if (step_reg[3:2] + step_reg[1:0] < 3'd4)
                                res_reg[step_reg[1:0] + step_reg[3:2]] <=
                                    fadd(res_reg[step_reg[1:0] + step_reg[3:2]], mr);
                            else
                                d_reg[2'(step_reg[1:0] + step_reg[3:2])] <=
                                    (step_reg[1:0] == 2'd3)
                                    ? mr : fadd(d_reg[2'(step_reg[1:0] + step_reg[3:2])], mr);
                            if (step_reg[3:0] == 4'd15)
                            begin
                                res_reg[1] <= d_reg[0];
                                res_reg[2] <= d_reg[1];
                                res_reg[3] <= mr;
                                acc_reg[0] <= res_reg[0];
                                acc_reg[1] <= res_reg[1];
                                acc_reg[2] <= res_reg[2];
                                acc_reg[3] <= res_reg[3];
                            end
                        end
                        else
                        begin
                            res_reg[step_reg[1:0]] <=
                                fadd(acc_reg[step_reg[1:0]], mr);
                            if (step_reg[1:0] == 2'd2)
                            begin
                                res_reg[3] <= acc_reg[3];
                                state_reg <= S_OUT;
                            end
                        end
                    end
                    else
                        wb_reg <= wb_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == S_IDLE))
        else $error("item taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !out_valid)
        else $error("result during clear pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid)
        else $error("result not posted");
endmodule
`default_nettype wire
